@@ hw/rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths, types and constants of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [1:0]       cnt_t;

  localparam cp_t   Replacement = cp_t'(21'h00FFFD);

  localparam byte_t ContMask  = 8'hC0;
  localparam byte_t ContCode  = 8'h80;
  localparam byte_t Lead2Mask = 8'hE0;
  localparam byte_t Lead2Code = 8'hC0;
  localparam byte_t Lead3Mask = 8'hF0;
  localparam byte_t Lead3Code = 8'hE0;
  localparam byte_t Lead4Mask = 8'hF8;
  localparam byte_t Lead4Code = 8'hF0;
  localparam byte_t ContBits  = 8'h3F;
  localparam byte_t Lead2Bits = 8'h1F;
  localparam byte_t Lead3Bits = 8'h0F;
  localparam byte_t Lead4Bits = 8'h07;

endpackage

@@ hw/rtl/u8d_if.sv @@
// ----------------------------------------------------------------------------
// u8d_byte_if / u8d_cp_if
// Valid/ready channels for the byte stream and for decoded code points.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic           valid;
  logic           ready;
  u8d_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
  logic         valid;
  logic         ready;
  u8d_pkg::cp_t code_point;
  logic         malformed;
  logic         end_of_text;
  logic         run_last;

  modport source (output valid, output code_point, output malformed,
                  output end_of_text, output run_last, input ready);
  modport sink   (input valid, input code_point, input malformed,
                  input end_of_text, input run_last, output ready);
endinterface

@@ hw/rtl/utf8_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Streaming UTF-8 decoder: one byte per request in, code points out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | request
//  in_ch    | in  | in_byte[7:0]                                   | one byte
//  out_ch   | out | code_point[20:0] malformed end_of_text run_last | one result
//
//  A byte is decoded in the cycle it is accepted; its results are held in the
//  result register, one delivered per cycle while out_ch.ready is high. A byte
//  with at most one result sustains one byte per cycle while the output is
//  ready; a broken sequence gives up to four results and the input waits while
//  they drain. A new byte is accepted in the cycle the final result of the
//  previous one is taken. Reset clears the open sequence and result valid flags.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8d_byte_if.sink     in_ch,
  u8d_cp_if.source     out_ch
);

  u8d_pkg::cnt_t  need_q, need_d;
  u8d_pkg::cnt_t  taken_q, taken_d;
  u8d_pkg::cp_t   part_q, part_d;
  u8d_pkg::cnt_t  rep_q, rep_d;
  logic           fin_q, fin_d;
  u8d_pkg::cp_t   cp_q, cp_d;
  logic           bad_q, bad_d;
  logic           eot_q, eot_d;

  u8d_pkg::byte_t b;
  u8d_pkg::cnt_t  taken_inc;
  u8d_pkg::cp_t   part_ext;
  logic           seq_open;
  logic           is_cont;
  logic           accept;
  logic           out_fire;

  assign b         = in_ch.in_byte;
  assign seq_open  = (need_q != 2'd0);
  assign is_cont   = ((b & u8d_pkg::ContMask) == u8d_pkg::ContCode);
  assign taken_inc = taken_q + 2'd1;
  assign part_ext  = {part_q[u8d_pkg::CpW-7:0], b[5:0]};

  assign out_ch.valid       = (rep_q != 2'd0) || fin_q;
  assign out_ch.code_point  = (rep_q != 2'd0) ? u8d_pkg::Replacement : cp_q;
  assign out_ch.malformed   = (rep_q != 2'd0) || bad_q;
  assign out_ch.end_of_text = (rep_q == 2'd0) && eot_q;
  assign out_ch.run_last    = (rep_q == 2'd0) || ((rep_q == 2'd1) && !fin_q);

  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !out_ch.valid || (out_ch.ready && out_ch.run_last);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    need_d  = need_q;
    taken_d = taken_q;
    part_d  = part_q;
    rep_d   = rep_q;
    fin_d   = fin_q;
    cp_d    = cp_q;
    bad_d   = bad_q;
    eot_d   = eot_q;
    if (accept) begin
      rep_d = 2'd0;
      fin_d = 1'b0;
      bad_d = 1'b0;
      eot_d = 1'b0;
      if (seq_open && is_cont) begin
        if (taken_inc >= need_q) begin
          fin_d   = 1'b1;
          cp_d    = part_ext;
          need_d  = 2'd0;
          taken_d = 2'd0;
          part_d  = '0;
        end else begin
          taken_d = taken_inc;
          part_d  = part_ext;
        end
      end else begin
        rep_d   = seq_open ? taken_inc : 2'd0;
        need_d  = 2'd0;
        taken_d = 2'd0;
        part_d  = '0;
        if (b == 8'h00) begin
          fin_d = 1'b1;
          cp_d  = '0;
          eot_d = 1'b1;
        end else if (!b[7]) begin
          fin_d = 1'b1;
          cp_d  = u8d_pkg::cp_t'(b);
        end else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
          need_d = 2'd1;
          part_d = u8d_pkg::cp_t'(b & u8d_pkg::Lead2Bits);
        end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
          need_d = 2'd2;
          part_d = u8d_pkg::cp_t'(b & u8d_pkg::Lead3Bits);
        end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
          need_d = 2'd3;
          part_d = u8d_pkg::cp_t'(b & u8d_pkg::Lead4Bits);
        end else begin
          fin_d = 1'b1;
          cp_d  = u8d_pkg::Replacement;
          bad_d = 1'b1;
        end
      end
    end else if (out_fire) begin
      if (rep_q != 2'd0) begin
        rep_d = rep_q - 2'd1;
      end else begin
        fin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q  <= 2'd0;
      taken_q <= 2'd0;
      part_q  <= '0;
      rep_q   <= 2'd0;
      fin_q   <= 1'b0;
    end else begin
      need_q  <= need_d;
      taken_q <= taken_d;
      part_q  <= part_d;
      rep_q   <= rep_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q  <= cp_d;
    bad_q <= bad_d;
    eot_q <= eot_d;
  end

`ifndef SYNTHESIS
  a_taken_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q != 2'd0) |-> (taken_q < need_q))
    else $error("taken continuations not below needed count");

  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0) |-> (taken_q == 2'd0))
    else $error("continuation count left over with no open sequence");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_ch.run_last) |=> out_ch.valid)
    else $error("result run ended before its final result");

  a_eot_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.end_of_text) |->
      (out_ch.code_point == '0 && !out_ch.malformed && out_ch.run_last))
    else $error("end-of-text result has a bad shape");

  a_bad_is_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.malformed) |-> (out_ch.code_point == u8d_pkg::Replacement))
    else $error("malformed result is not the replacement character");
`endif

endmodule
